FILE: src/gfq_pair_adjacency_test_top_defines.svh
// Assertion macros for the pair adjacency test block.
// Used by the top level only; the macros expect clk and rst in scope.
`ifndef GFQ_PAIR_ADJACENCY_TEST_TOP_DEFINES_SVH
`define GFQ_PAIR_ADJACENCY_TEST_TOP_DEFINES_SVH

// Same-cycle implication under the block reset.
`define GPAT_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpat: same-cycle check failed");

// Next-cycle implication under the block reset.
`define GPAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpat: next-cycle check failed");

`endif

FILE: src/gpat_pkg.sv
// Shared types and constants of the pair adjacency test block.
// No dependencies; used by the interfaces and the top level.
package gpat_pkg;

  typedef logic [1:0] class_t;

  localparam class_t CLASS_ZERO      = 2'd0;
  localparam class_t CLASS_SQUARE    = 2'd1;
  localparam class_t CLASS_NONSQUARE = 2'd2;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_MODULUS   = 2'd0;
  localparam reg_idx_t REG_NONSQUARE = 2'd1;
  localparam reg_idx_t REG_TARGET    = 2'd2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int MODULUS_RESET   = 73;
  localparam int NONSQUARE_RESET = 5;

endpackage

FILE: src/gpat_ifs.sv
// Valid/ready channel interfaces for the pair adjacency test block.
// Depends on gpat_pkg for the class type.
interface gpat_pair_if #(parameter int W = 7);
  logic         valid;
  logic         ready;
  logic [W-2:0] left_direction;
  logic [W-1:0] left_offset;
  logic [W-2:0] right_direction;
  logic [W-1:0] right_offset;

  modport source (output valid, left_direction, left_offset, right_direction,
                  right_offset, input ready);
  modport sink (input valid, left_direction, left_offset, right_direction,
                right_offset, output ready);
endinterface

interface gpat_result_if #(parameter int W = 7);
  logic              valid;
  logic              ready;
  logic              adjacent;
  logic [W-1:0]      node_residue;
  gpat_pkg::class_t  node_class;

  modport source (output valid, adjacent, node_residue, node_class, input ready);
  modport sink (input valid, adjacent, node_residue, node_class, output ready);
endinterface

FILE: src/gfq_pair_adjacency_test_top.sv
// Top level of the pair adjacency test over GF(q): APB registers, the
// arithmetic pipeline and assertions. Depends on gpat_pkg, gpat_ifs,
// gpat_modmul, gpat_modexp and gfq_pair_adjacency_test_top_defines.svh.
//
// The block takes one vertex pair per clock while the result side does not
// stall and returns one result item per pair, in order. Every modular product
// goes through a three-stage multiplier (product, upper half of the reduction,
// lower half), and each Fermat/Euler exponentiation is a chain of FIELD_BITS
// such multiplier steps. The sequence is: reduce the inputs, invert a_l and
// a_r, form the six cross products, invert det, form x*y and dinv^2, multiply
// them, subtract the nonsquare, then raise the node to (q-1)/2. The whole
// pipeline moves as one: it advances whenever the result register is empty or
// its item is being taken, and pair.ready follows that condition, so a stall
// on the result side holds every item in place. Registers: modulus at byte 0,
// nonsquare_value at byte 4, target_is_square at byte 8; they must only be
// written while no item is in flight. A modulus below three, or equal
// directions, give an all-zero result.

`include "gfq_pair_adjacency_test_top_defines.svh"

module gfq_pair_adjacency_test_top #(
  parameter int FIELD_BITS = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  gpat_pair_if.sink                      pair,
  gpat_result_if.source                  result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gpat_pkg::ADDR_W-1:0]    paddr,
  input  logic [gpat_pkg::DATA_W-1:0]    pwdata,
  output logic [gpat_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int W = FIELD_BITS;

  // Configuration registers.
  logic [W-1:0] modulus;
  logic [W-1:0] nonsquare;
  logic         target_sq;

  gpat_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= W'(gpat_pkg::MODULUS_RESET);
      nonsquare <= W'(gpat_pkg::NONSQUARE_RESET);
      target_sq <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        gpat_pkg::REG_MODULUS:   modulus   <= pwdata[W-1:0];
        gpat_pkg::REG_NONSQUARE: nonsquare <= pwdata[W-1:0];
        gpat_pkg::REG_TARGET:    target_sq <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gpat_pkg::REG_MODULUS:   prdata = gpat_pkg::DATA_W'(modulus);
      gpat_pkg::REG_NONSQUARE: prdata = gpat_pkg::DATA_W'(nonsquare);
      gpat_pkg::REG_TARGET:    prdata = gpat_pkg::DATA_W'(target_sq);
      default:                 prdata = '0;
    endcase
  end

  // Exponents: q-2 for inverses, (q-1)/2 for Euler's criterion.
  logic [W-1:0] exp_inv;
  logic [W-1:0] exp_half;

  assign exp_inv  = modulus - W'(2);
  assign exp_half = (modulus - W'(1)) >> 1;

  // Pipeline advance: the result register is free or being emptied.
  logic adv;
  logic out_valid;

  assign adv        = !out_valid || result.ready;
  assign pair.ready = adv;

  // Modular subtraction of two values already below q.
  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] x_a,
                                           input logic [W-1:0] x_b,
                                           input logic [W-1:0] x_q);
    logic [W:0] t;
    t = {1'b0, x_a} + {1'b0, x_q} - {1'b0, x_b};
    if (t >= {1'b0, x_q}) begin
      t = t - {1'b0, x_q};
    end
    return t[W-1:0];
  endfunction

  // Stage A: reduce the raw fields modulo q (multiply by one).
  logic         in_zero;
  logic [W-1:0] dl_inc;
  logic [W-1:0] dr_inc;

  assign in_zero = (modulus < W'(3)) || (pair.left_direction == pair.right_direction);
  assign dl_inc  = W'(pair.left_direction) + W'(1);
  assign dr_inc  = W'(pair.right_direction) + W'(1);

  logic         a_valid, a_zero;
  logic [W-1:0] a_al, a_ar, a_sl, a_sr, a_ns;

  gpat_modmul #(.W(W), .SIDE_W(1)) u_red_al (
    .clk(clk), .rst(rst), .en(adv), .in_valid(pair.valid && pair.ready),
    .a(dl_inc), .b(W'(1)), .q(modulus), .side_in(in_zero),
    .out_valid(a_valid), .prod(a_al), .side_out(a_zero)
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_red_ar (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(dr_inc), .b(W'(1)), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(a_ar), .side_out()
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_red_sl (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(pair.left_offset), .b(W'(1)), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(a_sl), .side_out()
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_red_sr (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(pair.right_offset), .b(W'(1)), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(a_sr), .side_out()
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_red_ns (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(nonsquare), .b(W'(1)), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(a_ns), .side_out()
  );

  // Stage B: b_l and b_r by Fermat inversion; the reduced fields ride along.
  localparam int SB_W = 5 * W + 1;

  logic            b_valid, b_zero;
  logic [W-1:0]    b_bl, b_br, b_al, b_ar, b_sl, b_sr, b_ns;
  logic [SB_W-1:0] b_side;

  gpat_modexp #(.W(W), .SIDE_W(SB_W)) u_inv_l (
    .clk(clk), .rst(rst), .en(adv), .in_valid(a_valid),
    .base_in(a_al), .expo(exp_inv), .q(modulus),
    .side_in({a_al, a_ar, a_sl, a_sr, a_ns, a_zero}),
    .out_valid(b_valid), .result(b_bl), .side_out(b_side)
  );
  gpat_modexp #(.W(W), .SIDE_W(1)) u_inv_r (
    .clk(clk), .rst(rst), .en(adv), .in_valid(a_valid),
    .base_in(a_ar), .expo(exp_inv), .q(modulus), .side_in(1'b0),
    .out_valid(), .result(b_br), .side_out()
  );

  assign {b_al, b_ar, b_sl, b_sr, b_ns, b_zero} = b_side;

  // Stage C: the six cross products behind det, x and y.
  logic         c_valid, c_zero;
  logic [W-1:0] c_albr, c_arbl, c_blsr, c_brsl, c_arsl, c_alsr, c_ns;

  gpat_modmul #(.W(W), .SIDE_W(W + 1)) u_albr (
    .clk(clk), .rst(rst), .en(adv), .in_valid(b_valid),
    .a(b_al), .b(b_br), .q(modulus), .side_in({b_ns, b_zero}),
    .out_valid(c_valid), .prod(c_albr), .side_out({c_ns, c_zero})
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_arbl (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(b_ar), .b(b_bl), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(c_arbl), .side_out()
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_blsr (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(b_bl), .b(b_sr), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(c_blsr), .side_out()
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_brsl (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(b_br), .b(b_sl), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(c_brsl), .side_out()
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_arsl (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(b_ar), .b(b_sl), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(c_arsl), .side_out()
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_alsr (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(b_al), .b(b_sr), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(c_alsr), .side_out()
  );

  logic [W-1:0] c_det, c_x, c_y;

  assign c_det = sub_mod(c_albr, c_arbl, modulus);
  assign c_x   = sub_mod(c_blsr, c_brsl, modulus);
  assign c_y   = sub_mod(c_arsl, c_alsr, modulus);

  // Stage E: inverse of det; a zero det comes out as zero.
  localparam int SE_W = 3 * W + 1;

  logic            e_valid, e_zero;
  logic [W-1:0]    e_dinv, e_x, e_y, e_ns;
  logic [SE_W-1:0] e_side;

  gpat_modexp #(.W(W), .SIDE_W(SE_W)) u_inv_det (
    .clk(clk), .rst(rst), .en(adv), .in_valid(c_valid),
    .base_in(c_det), .expo(exp_inv), .q(modulus),
    .side_in({c_x, c_y, c_ns, c_zero}),
    .out_valid(e_valid), .result(e_dinv), .side_out(e_side)
  );

  assign {e_x, e_y, e_ns, e_zero} = e_side;

  // Stage F: x*y and dinv^2 side by side.
  logic         f_valid, f_zero;
  logic [W-1:0] f_xy, f_dd, f_ns;

  gpat_modmul #(.W(W), .SIDE_W(W + 1)) u_xy (
    .clk(clk), .rst(rst), .en(adv), .in_valid(e_valid),
    .a(e_x), .b(e_y), .q(modulus), .side_in({e_ns, e_zero}),
    .out_valid(f_valid), .prod(f_xy), .side_out({f_ns, f_zero})
  );
  gpat_modmul #(.W(W), .SIDE_W(1)) u_dd (
    .clk(clk), .rst(rst), .en(adv), .in_valid(1'b0),
    .a(e_dinv), .b(e_dinv), .q(modulus), .side_in(1'b0),
    .out_valid(), .prod(f_dd), .side_out()
  );

  // Stage G: the node product, then the nonsquare is taken off.
  logic         g_valid, g_zero;
  logic [W-1:0] g_prod, g_ns, g_node;

  gpat_modmul #(.W(W), .SIDE_W(W + 1)) u_node (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f_valid),
    .a(f_xy), .b(f_dd), .q(modulus), .side_in({f_ns, f_zero}),
    .out_valid(g_valid), .prod(g_prod), .side_out({g_ns, g_zero})
  );

  assign g_node = sub_mod(g_prod, g_ns, modulus);

  // Stage H: Euler's criterion on the node.
  logic         h_valid, h_zero;
  logic [W-1:0] h_euler, h_node;

  gpat_modexp #(.W(W), .SIDE_W(W + 1)) u_euler (
    .clk(clk), .rst(rst), .en(adv), .in_valid(g_valid),
    .base_in(g_node), .expo(exp_half), .q(modulus),
    .side_in({g_node, g_zero}),
    .out_valid(h_valid), .result(h_euler), .side_out({h_node, h_zero})
  );

  // Classification and the result register.
  gpat_pkg::class_t h_class;
  logic             h_adj;

  always_comb begin
    if (h_zero || (h_node == '0)) begin
      h_class = gpat_pkg::CLASS_ZERO;
    end else if (h_euler == W'(1)) begin
      h_class = gpat_pkg::CLASS_SQUARE;
    end else begin
      h_class = gpat_pkg::CLASS_NONSQUARE;
    end
    h_adj = (h_class != gpat_pkg::CLASS_ZERO) &&
            (h_class == (target_sq ? gpat_pkg::CLASS_SQUARE : gpat_pkg::CLASS_NONSQUARE));
  end

  logic             out_adj;
  logic [W-1:0]     out_node;
  gpat_pkg::class_t out_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_adj   <= h_adj;
      out_node  <= h_zero ? '0 : h_node;
      out_class <= h_class;
    end
  end

  assign result.valid        = out_valid;
  assign result.adjacent     = out_adj;
  assign result.node_residue = out_node;
  assign result.node_class   = out_class;

  // A waiting result must freeze the whole pipeline, input included.
  `GPAT_ASSERT_IMPLIES(a_stall_blocks_input, out_valid && !result.ready, !pair.ready)
  // An adjacent pair never has a zero character.
  `GPAT_ASSERT_IMPLIES(a_adj_nonzero, out_valid && out_adj, out_class != gpat_pkg::CLASS_ZERO)
  // The node stays reduced below a proper modulus.
  `GPAT_ASSERT_IMPLIES(a_node_reduced, out_valid && (modulus >= W'(3)), out_node < modulus)
  // A modulus write lands in the register.
  `GPAT_ASSERT_NEXT(a_modulus_write,
    cfg_wr && (reg_idx == gpat_pkg::REG_MODULUS), modulus == $past(pwdata[W-1:0]))

endmodule

FILE: src/gpat_modmul.sv
// Three-stage modular multiplier: product, then two halves of a
// shift-and-subtract reduction. No package dependencies.
module gpat_modmul #(
  parameter int W      = 7,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  input  logic [W-1:0]      q,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [W-1:0]      prod,
  output logic [SIDE_W-1:0] side_out
);

  localparam int PW = 2 * W;
  localparam int LO = W / 2;

  logic              v1, v2, v3;
  logic [PW-1:0]     p1, p2;
  logic [W-1:0]      p3;
  logic [SIDE_W-1:0] s1, s2, s3;
  logic [PW-1:0]     red_hi, red_lo;

  // Either both operands are below q or one of them is one, so the product is below q * 2^W.
  always_comb begin
    red_hi = p1;
    for (int k = W - 1; k >= LO; k--) begin
      if (red_hi >= (PW'(q) << k)) begin
        red_hi = red_hi - (PW'(q) << k);
      end
    end
  end

  always_comb begin
    red_lo = p2;
    for (int k = LO - 1; k >= 0; k--) begin
      if (red_lo >= (PW'(q) << k)) begin
        red_lo = red_lo - (PW'(q) << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= PW'(a) * PW'(b);
      s1 <= side_in;
      p2 <= red_hi;
      s2 <= s1;
      p3 <= red_lo[W-1:0];
      s3 <= s2;
    end
  end

  assign out_valid = v3;
  assign prod      = p3;
  assign side_out  = s3;

endmodule

FILE: src/gpat_modexp.sv
// Pipelined modular exponentiation, one square-and-multiply step per exponent
// bit, each step two gpat_modmul units. No package dependencies.
module gpat_modexp #(
  parameter int W      = 7,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [W-1:0]      base_in,
  input  logic [W-1:0]      expo,
  input  logic [W-1:0]      q,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [W-1:0]      result,
  output logic [SIDE_W-1:0] side_out
);

  logic [W-1:0]      acc  [W+1];
  logic [W-1:0]      pw   [W+1];
  logic [SIDE_W-1:0] sd   [W+1];
  logic              vd   [W+1];

  assign acc[0] = W'(1);
  assign pw[0]  = base_in;
  assign sd[0]  = side_in;
  assign vd[0]  = in_valid;

  // Right-to-left: the running product takes the current power when the
  // exponent bit is set, while the power is squared alongside it.
  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W-1:0] mult_op;
    assign mult_op = expo[i] ? pw[i] : W'(1);

    gpat_modmul #(.W(W), .SIDE_W(SIDE_W)) u_acc (
      .clk(clk), .rst(rst), .en(en), .in_valid(vd[i]),
      .a(acc[i]), .b(mult_op), .q(q), .side_in(sd[i]),
      .out_valid(vd[i+1]), .prod(acc[i+1]), .side_out(sd[i+1])
    );

    gpat_modmul #(.W(W), .SIDE_W(1)) u_sq (
      .clk(clk), .rst(rst), .en(en), .in_valid(vd[i]),
      .a(pw[i]), .b(pw[i]), .q(q), .side_in(1'b0),
      .out_valid(), .prod(pw[i+1]), .side_out()
    );
  end

  assign out_valid = vd[W];
  assign result    = acc[W];
  assign side_out  = sd[W];

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the GF(q) pair adjacency test block: queue-fed driver,
// clocked monitor with an in-bench predictor, APB register writes between phases.
// Depends on gpat_pkg, gpat_ifs and the block's top level.
module tb_top;

  localparam int FB = 7;
  // Pipeline depth of the top level, reckoned from its stages; the drain adds a margin.
  localparam int LATENCY = 9 * FB + 13;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [FB-2:0] ldir;
    logic [FB-1:0] loff;
    logic [FB-2:0] rdir;
    logic [FB-1:0] roff;
  } pair_t;

  typedef struct packed {
    logic             adj;
    logic [FB-1:0]    node;
    gpat_pkg::class_t cls;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [gpat_pkg::ADDR_W-1:0] paddr = '0;
  logic [gpat_pkg::DATA_W-1:0] pwdata = '0;
  logic [gpat_pkg::DATA_W-1:0] prdata;
  logic pready;

  gpat_pair_if #(FB)   pair_ch ();
  gpat_result_if #(FB) res_ch ();

  gfq_pair_adjacency_test_top #(.FIELD_BITS(FB)) i_dut (
    .clk(clk), .rst(rst), .pair(pair_ch.sink), .result(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The bench's own copy of the registers, updated as each write completes.
  int unsigned cur_mod = gpat_pkg::MODULUS_RESET;
  int unsigned cur_nsq = gpat_pkg::NONSQUARE_RESET;
  bit          cur_tgt = 1'b1;

  pair_t    pending_pairs[$];
  verdict_t awaited[$];
  int       errors = 0;
  bit       pressure = 1'b0;

  function automatic int unsigned mod_pow(int unsigned b, int unsigned e,
                                          int unsigned q);
    int unsigned r;
    r = 1;
    b = b % q;
    while (e != 0) begin
      if (e[0]) r = (r * b) % q;
      b = (b * b) % q;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic int unsigned sub_mod(int unsigned a, int unsigned b,
                                          int unsigned q);
    return ((a % q) + q - (b % q)) % q;
  endfunction

  // Works out the adjacency verdict for one pair under the current registers.
  function automatic verdict_t adjacency_of(pair_t p);
    verdict_t v;
    int unsigned q, al, ar, bl, br, det, dinv, x, y, nd, e;
    v = '0;
    q = cur_mod;
    if (q < 3 || p.ldir == p.rdir) return v;
    al = (p.ldir + 1) % q;
    ar = (p.rdir + 1) % q;
    bl = mod_pow(al, q - 2, q);
    br = mod_pow(ar, q - 2, q);
    det = sub_mod((al * br) % q, (ar * bl) % q, q);
    dinv = mod_pow(det, q - 2, q);
    x = sub_mod((bl * (p.roff % q)) % q, (br * (p.loff % q)) % q, q);
    y = sub_mod((ar * (p.loff % q)) % q, (al * (p.roff % q)) % q, q);
    nd = (((x * y) % q) * ((dinv * dinv) % q)) % q;
    nd = sub_mod(nd, cur_nsq, q);
    v.node = nd[FB-1:0];
    if (nd == 0) begin
      v.cls = gpat_pkg::CLASS_ZERO;
    end else begin
      e = mod_pow(nd, (q - 1) >> 1, q);
      v.cls = (e == 1) ? gpat_pkg::CLASS_SQUARE : gpat_pkg::CLASS_NONSQUARE;
    end
    v.adj = (v.cls != gpat_pkg::CLASS_ZERO) &&
            (v.cls == (cur_tgt ? gpat_pkg::CLASS_SQUARE : gpat_pkg::CLASS_NONSQUARE));
    return v;
  endfunction

  // Gap length: mostly nothing, sometimes short, rarely long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: offers the head of the pending queue, with random gaps in between.
  int src_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      pair_ch.valid <= 1'b0;
      pair_ch.left_direction <= '0;
      pair_ch.left_offset <= '0;
      pair_ch.right_direction <= '0;
      pair_ch.right_offset <= '0;
    end else begin
      if (pair_ch.valid && pair_ch.ready) begin
        // The prediction uses the registers as they stand while it is in flight.
        awaited = {awaited, adjacency_of(pending_pairs.pop_front())};
        src_gap = gap_len();
      end
      if (pair_ch.valid && !pair_ch.ready) begin
        // Still waiting for acceptance; keep offering the same item.
      end else if (src_gap > 0 || pending_pairs.size() == 0) begin
        if (src_gap > 0) src_gap--;
        pair_ch.valid <= 1'b0;
      end else begin
        pair_ch.valid <= 1'b1;
        pair_ch.left_direction <= pending_pairs[0].ldir;
        pair_ch.left_offset <= pending_pairs[0].loff;
        pair_ch.right_direction <= pending_pairs[0].rdir;
        pair_ch.right_offset <= pending_pairs[0].roff;
      end
    end
  end

  // Monitor: random back-pressure, one long hold-off counted here, and a check
  // of every result item taken.
  int snk_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (awaited.size() == 0) begin
          $error("result item arrived with nothing expected");
          errors++;
        end else begin
          want = awaited.pop_front();
          if (res_ch.adjacent !== want.adj) begin
            $error("adjacent: expected %0d, got %0d", want.adj, res_ch.adjacent);
            errors++;
          end
          if (res_ch.node_residue !== want.node) begin
            $error("node_residue: expected %0d, got %0d", want.node,
                   res_ch.node_residue);
            errors++;
          end
          if (res_ch.node_class !== want.cls) begin
            $error("node_class: expected %0d, got %0d", want.cls,
                   res_ch.node_class);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (pressure && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        snk_gap = gap_len();
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel and no APB select.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // APB write: setup then access; pready is always high.
  task automatic write_reg(gpat_pkg::reg_idx_t idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= gpat_pkg::ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      gpat_pkg::REG_MODULUS:   cur_mod = value & 7'h7f;
      gpat_pkg::REG_NONSQUARE: cur_nsq = value & 7'h7f;
      default:                 cur_tgt = value[0];
    endcase
  endtask

  // Waits for the block to go quiet before registers may change.
  task automatic drain();
    wait (pending_pairs.size() == 0 && awaited.size() == 0 && !pair_ch.valid);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic queue_pair(pair_t p);
    pending_pairs = {pending_pairs, p};
  endtask

  function automatic pair_t pick_pair(int unsigned q);
    pair_t p;
    int unsigned h;
    h = (q > 4) ? (q - 1) / 2 - 1 : 0;
    // Most pairs stay in range; a few use the whole field width.
    if ($urandom_range(0, 9) == 0) begin
      p = pair_t'($urandom());
    end else begin
      p.ldir = (FB-1)'($urandom_range(0, h));
      p.rdir = ($urandom_range(0, 7) == 0) ? p.ldir : (FB-1)'($urandom_range(0, h));
      p.loff = FB'($urandom_range(0, (q > 0) ? q - 1 : 0));
      p.roff = FB'($urandom_range(0, (q > 0) ? q - 1 : 0));
    end
    return p;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) queue_pair(pick_pair(cur_mod));
    drain();
  endtask

  initial begin
    pair_t p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed part under the reset registers: extremes, same direction,
    // out-of-range fields and the all-ones offsets.
    queue_pair('{6'd0, 7'd0, 6'd1, 7'd0});
    queue_pair('{6'd5, 7'd3, 6'd5, 7'd9});
    queue_pair('{6'd0, 7'd72, 6'd35, 7'd72});
    queue_pair('{6'd63, 7'd127, 6'd0, 7'd127});
    queue_pair('{6'd62, 7'd126, 6'd63, 7'd0});
    queue_pair('{6'd0, 7'd0, 6'd40, 7'd1});
    queue_pair('{6'd3, 7'd10, 6'd20, 7'd44});
    queue_pair('{6'h2a, 7'h55, 6'h15, 7'h2a});
    for (int i = 0; i < 8; i++) begin
      p = pick_pair(73);
      queue_pair(p);
    end
    drain();

    // The result side holds off for a long stretch while pairs keep coming,
    // so the pipeline fills and the input stalls.
    pressure = 1'b1;
    for (int i = 0; i < 150; i++) queue_pair(pick_pair(73));
    drain();

    // Target nonsquare, then the smallest field.
    write_reg(gpat_pkg::REG_TARGET, 0);
    random_phase(80);
    write_reg(gpat_pkg::REG_MODULUS, 3);
    write_reg(gpat_pkg::REG_NONSQUARE, 2);
    write_reg(gpat_pkg::REG_TARGET, 1);
    random_phase(50);
    // Largest prime.
    write_reg(gpat_pkg::REG_MODULUS, 127);
    write_reg(gpat_pkg::REG_NONSQUARE, 3);
    random_phase(120);
    write_reg(gpat_pkg::REG_NONSQUARE, 126);
    write_reg(gpat_pkg::REG_TARGET, 0);
    random_phase(60);
    // A modulus below three gives all-zero results.
    write_reg(gpat_pkg::REG_MODULUS, 1);
    random_phase(25);
    // A composite modulus, then the top register value with a nonsquare
    // register equal to q.
    write_reg(gpat_pkg::REG_MODULUS, 15);
    write_reg(gpat_pkg::REG_NONSQUARE, 2);
    random_phase(40);
    write_reg(gpat_pkg::REG_MODULUS, 127);
    write_reg(gpat_pkg::REG_NONSQUARE, 127);
    random_phase(30);
    write_reg(gpat_pkg::REG_MODULUS, 11);
    write_reg(gpat_pkg::REG_NONSQUARE, 2);
    write_reg(gpat_pkg::REG_TARGET, 1);
    random_phase(100);
    write_reg(gpat_pkg::REG_MODULUS, 73);
    write_reg(gpat_pkg::REG_NONSQUARE, 5);
    random_phase(60);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
